// ===== rtl/core/rau_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic package
// Shared types, opcodes and widths for the rational arithmetic unit.
// ---------------------------------------------------------------------------
package rau_pkg;

	localparam int OperandWidth = 16;
	localparam int NumW = 33;
	localparam int DenW = 31;

	typedef enum logic [2:0] {
		OP_NORM = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_EQ   = 3'd5,
		OP_LT   = 3'd6,
		OP_GT   = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]                    opcode;
		logic signed [OperandWidth-1:0] a_num;
		logic signed [OperandWidth-1:0] a_den;
		logic signed [OperandWidth-1:0] b_num;
		logic signed [OperandWidth-1:0] b_den;
	} in_beat_t;

	typedef struct packed {
		logic signed [NumW-1:0] res_num;
		logic [DenW-1:0]        res_den;
		logic                   cmp_true;
	} out_beat_t;

	// Raw fraction handed from the front part to the reduction engine.
	// Values are held at 64 bits; the products of two 16-bit operands fit.
	typedef struct packed {
		logic               is_cmp;
		logic               flag;
		logic signed [63:0] n;
		logic signed [63:0] d;
	} job_t;

	// Front end sequence: idle, first and second multiply, job held for the queue.
	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL1,
		FR_MUL2,
		FR_HOLD
	} fstate_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} rstate_t;

endpackage
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add, sub, mul, div, normalize and compare with GCD reduction.
// ---------------------------------------------------------------------------
// Comparisons and zero cases pass the front end and the queue and go straight
// to the result register; reduced fractions first run the GCD modulo steps
// and the exact divisions of numerator and denominator by the GCD. The front
// end takes no new beat until the queue has taken its job; the reduction
// engine works on one job at a time and sets the rate.
// Reset: arst_n clears all control state asynchronously; no clearing pass.
module rational_arithmetic_unit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire rau_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire                     out_stall,
	output rau_pkg::out_beat_t      out_data
);
	import rau_pkg::*;

	job_t f_job, q_job;
	logic f_valid, f_stall, q_valid, q_stall;

	// Front end: takes a beat, builds cross-products.
	rau_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .data(in_data),
		.job_valid(f_valid), .job_stall(f_stall), .job(f_job)
	);

	// Queue lets each side stall on its own.
	rau_queue u_queue (
		.clk, .arst_n, .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
		.out_valid(q_valid), .out_stall(q_stall), .out_job(q_job)
	);

	// Back end: GCD reduction and result register.
	rau_reduce u_reduce (
		.clk, .arst_n, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
		.valid(out_valid), .stall(out_stall), .data(out_data)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.cmp_true && out_data.res_num != '0))
		else $error("comparison with nonzero numerator");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.cmp_true |-> out_data.res_den == DenW'(1))
		else $error("comparison with denominator other than one");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input beat withdrawn while stalled");

endmodule
`default_nettype wire

// ===== rtl/core/rau_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Rational front end
// Accepts beats, forms cross-products in its multiply states and emits raw jobs.
// ---------------------------------------------------------------------------
module rau_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     valid,
	output logic                    stall,
	input  wire rau_pkg::in_beat_t  data,
	output logic                    job_valid,
	input  wire                     job_stall,
	output rau_pkg::job_t           job
);
	import rau_pkg::*;

	localparam int W = OperandWidth;

	// Idle, first and second multiply, then the job is held until the queue takes it.
	fstate_t ph_q, ph_d;
	op_t op_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [63:0] lx_q, rx_q, dd_q, pp_q;
	logic signed [W-1:0] m1a, m1b, m2a, m2b;
	logic signed [2*W-1:0] p1, p2;
	job_t job_d;

	assign stall = (ph_q != FR_IDLE);
	assign job_valid = (ph_q == FR_HOLD);

	always_comb begin
		ph_d = ph_q;
		unique case (ph_q)
			FR_IDLE: if (valid) ph_d = FR_MUL1;
			FR_MUL1: ph_d = FR_MUL2;
			FR_MUL2: ph_d = FR_HOLD;
			FR_HOLD: if (!job_stall) ph_d = FR_IDLE;
		endcase
	end

	// One 2-multiplier set, shared by FR_MUL1 and FR_MUL2.
	always_comb begin
		if (ph_q == FR_MUL1) begin
			m1a = an_q; m1b = bd_q; m2a = bn_q; m2b = ad_q;
		end else begin
			m1a = ad_q; m1b = (op_q == OP_DIV) ? bn_q : bd_q;
			m2a = an_q; m2b = bn_q;
		end
	end
	assign p1 = m1a * m1b;
	assign p2 = m2a * m2b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= FR_IDLE;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == FR_IDLE && valid) begin
			op_q <= op_t'(data.opcode);
			an_q <= W'(data.a_num);
			ad_q <= W'(data.a_den);
			bn_q <= W'(data.b_num);
			bd_q <= W'(data.b_den);
		end
		if (ph_q == FR_MUL1) begin
			lx_q <= 64'(p1);
			rx_q <= 64'(p2);
		end
		if (ph_q == FR_MUL2) begin
			dd_q <= 64'(p1);
			pp_q <= 64'(p2);
		end
	end

	always_comb begin
		job_d.is_cmp = 1'b0;
		job_d.flag = 1'b0;
		job_d.n = lx_q;
		job_d.d = dd_q;
		unique case (op_q)
			OP_NORM: begin job_d.n = 64'(an_q); job_d.d = 64'(ad_q); end
			OP_ADD:  job_d.n = lx_q + rx_q;
			OP_SUB:  job_d.n = lx_q - rx_q;
			OP_MUL:  job_d.n = pp_q;
			OP_DIV:  job_d.n = lx_q;
			OP_EQ:   begin job_d.is_cmp = 1'b1; job_d.flag = (lx_q == rx_q); end
			OP_LT:   begin job_d.is_cmp = 1'b1; job_d.flag = (lx_q < rx_q); end
			default: begin job_d.is_cmp = 1'b1; job_d.flag = (lx_q > rx_q); end
		endcase
	end
	assign job = job_d;

endmodule
`default_nettype wire

// ===== rtl/core/rau_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Rational job queue
// Two-entry queue decoupling the front end from the reduction engine.
// ---------------------------------------------------------------------------
module rau_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire rau_pkg::job_t  in_job,
	output logic                out_valid,
	input  wire                 out_stall,
	output rau_pkg::job_t       out_job
);
	import rau_pkg::*;

	job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job   = mem_q[rp_q];
	assign push = in_valid && !in_stall;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/rau_reduce.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Rational reduction engine
// Binary-restoring modulo GCD and exact divisions, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rau_reduce (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 job_valid,
	output logic                job_stall,
	input  wire rau_pkg::job_t  job,
	output logic                valid,
	input  wire                 stall,
	output rau_pkg::out_beat_t  data
);
	import rau_pkg::*;

	localparam int MW = 63;

	rstate_t st_q, st_d;
	logic [MW-1:0] x_q, y_q;       // GCD operands
	logic [MW-1:0] rem_q, dvs_q, quo_q, dvd_q;
	logic [5:0]    bit_q;
	logic          busy_mod_q;     // modulo sub-operation active in GCD
	logic          neg_q;
	logic          cmp_q, flag_q;
	logic [MW-1:0] an_q, ad_q;     // magnitudes of numerator, denominator
	logic          nneg_q;
	logic [MW-1:0] g_q, qn_q;
	logic signed [64:0] pn_q, pd_q;
	logic [MW:0] trial;
	logic [MW-1:0] rsh;
	logic [MW-1:0] nabs, dabs;

	// Shared restoring divider step: rem = (rem<<1 | next dividend bit) - dvs.
	assign rsh   = {rem_q[MW-2:0], dvd_q[bit_q]};
	assign trial = {1'b0, rsh} - {1'b0, dvs_q};

	assign nabs = job.n[63] ? MW'(-job.n) : MW'(job.n);
	assign dabs = job.d[63] ? MW'(-job.d) : MW'(job.d);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (job_valid) begin
				if (job.is_cmp || job.d == 64'sd0 || job.n == 64'sd0) st_d = ST_DONE;
				else st_d = ST_GCD;
			end
			ST_GCD:  if (!busy_mod_q && (x_q == '0 || y_q == '0)) st_d = ST_DIVN;
			ST_DIVN: if (bit_q == 6'd0 && busy_mod_q) st_d = ST_DIVD;
			ST_DIVD: if (bit_q == 6'd0 && busy_mod_q) st_d = ST_DONE;
			default: if (!stall) st_d = ST_IDLE;
		endcase
	end

	assign job_stall = (st_q != ST_IDLE);
	assign valid = (st_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (job_valid) begin
				cmp_q <= job.is_cmp; flag_q <= job.flag;
				neg_q <= job.d[63];
				an_q <= nabs; ad_q <= dabs;
				nneg_q <= job.n[63];
				x_q <= nabs; y_q <= dabs;
				busy_mod_q <= 1'b0;
				pn_q <= job.d == 64'sd0 ? 65'(job.n) : 65'sd0;
				pd_q <= 65'sd1;
			end
			ST_GCD: begin
				if (!busy_mod_q) begin
					if (x_q != '0 && y_q != '0) begin
						busy_mod_q <= 1'b1; rem_q <= '0; bit_q <= 6'(MW-1);
						if (x_q > y_q) begin dvd_q <= x_q; dvs_q <= y_q; end
						else begin dvd_q <= y_q; dvs_q <= x_q; end
					end else begin
						g_q <= x_q + y_q;
						rem_q <= '0; bit_q <= 6'(MW-1); dvd_q <= an_q;
						dvs_q <= x_q + y_q; busy_mod_q <= 1'b1;
					end
				end else begin
					rem_q <= trial[MW] ? rsh : trial[MW-1:0];
					if (bit_q == 6'd0) begin
						busy_mod_q <= 1'b0;
						if (x_q > y_q) x_q <= trial[MW] ? rsh : trial[MW-1:0];
						else y_q <= trial[MW] ? rsh : trial[MW-1:0];
					end else bit_q <= bit_q - 6'd1;
				end
			end
			ST_DIVN, ST_DIVD: begin
				rem_q <= trial[MW] ? rsh : trial[MW-1:0];
				quo_q <= {quo_q[MW-2:0], ~trial[MW]};
				if (bit_q == 6'd0) begin
					if (st_q == ST_DIVN) begin
						qn_q <= {quo_q[MW-2:0], ~trial[MW]};
						rem_q <= '0; bit_q <= 6'(MW-1); dvd_q <= ad_q; dvs_q <= g_q;
					end else begin
						pn_q <= (nneg_q ^ neg_q) ? -65'(qn_q) : 65'(qn_q);
						pd_q <= 65'({quo_q[MW-2:0], ~trial[MW]});
					end
				end else bit_q <= bit_q - 6'd1;
			end
			default: ;
		endcase
	end

	// In ST_DIVN the busy flag marks the divider as loaded; it stays high.
	assign data.res_num  = cmp_q ? '0 : NumW'(pn_q);
	assign data.res_den  = cmp_q ? DenW'(1) : DenW'(pd_q);
	assign data.cmp_true = cmp_q & flag_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !cmp_q |-> data.res_den != '0)
		else $error("zero denominator delivered");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid && $stable(data))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIVN) |-> g_q != '0)
		else $error("zero divisor in reduction");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction beats through the valid/stall input channel, predicts each
// reduced fraction or comparison flag in the testbench, and checks every
// output beat against the oldest prediction, both idling at random in two phases.
// ---------------------------------------------------------------------------
module tb;
	import rau_pkg::*;

	localparam int NumRandom = 1750;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;

	// Idle rates in percent for the sender and the receiver.
	int send_idle_pct;
	int recv_idle_pct;
	// The sender holds off while this is set.
	bit hold_send;
	bit stim_done;

	in_beat_t pending_beats[$];
	out_beat_t expected_fracs[$];
	int mismatches = 0;
	// Beats taken by the block and beats put on the bus by the driver.
	int accepted_in = 0;
	int driven_cnt = 0;

	rational_arithmetic_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// Greatest common divisor by repeated modulo; both values nonnegative.
	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		while (x > 0 && y > 0) begin
			if (x > y) begin
				x = x % y;
			end else begin
				y = y % x;
			end
		end
		return x + y;
	endfunction

	// Reduce the raw fraction n/d so that the denominator is positive. A zero
	// denominator leaves the numerator untouched over one.
	function automatic out_beat_t reduce_frac(longint n, longint d);
		out_beat_t r;
		longint g;
		longint p;
		longint q;
		r = '0;
		if (d == 0) begin
			p = n;
			q = 1;
		end else begin
			g = longint'(gcd_of(n < 0 ? -n : n, d < 0 ? -d : d));
			if (d < 0) begin
				p = -n / g;
				q = -d / g;
			end else begin
				p = n / g;
				q = d / g;
			end
		end
		r.res_num = p[NumW-1:0];
		r.res_den = q[DenW-1:0];
		return r;
	endfunction

	// Expected output beat for one input beat. Operands are used exactly as
	// given, so comparisons treat the cross products literally.
	function automatic out_beat_t predict_frac(in_beat_t b);
		out_beat_t r;
		longint an;
		longint ad;
		longint bn;
		longint bd;
		longint lx;
		longint rx;
		an = longint'(b.a_num);
		ad = longint'(b.a_den);
		bn = longint'(b.b_num);
		bd = longint'(b.b_den);
		lx = an * bd;
		rx = bn * ad;
		r = '0;
		r.res_den = DenW'(1);
		case (op_t'(b.opcode))
			OP_NORM: r = reduce_frac(an, ad);
			OP_ADD:  r = reduce_frac(lx + rx, ad * bd);
			OP_SUB:  r = reduce_frac(lx - rx, ad * bd);
			OP_MUL:  r = reduce_frac(an * bn, ad * bd);
			OP_DIV:  r = reduce_frac(lx, ad * bn);
			OP_EQ:   r.cmp_true = (lx == rx);
			OP_LT:   r.cmp_true = (lx < rx);
			default: r.cmp_true = (lx > rx);
		endcase
		return r;
	endfunction

	function automatic logic [15:0] rand_operand();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3, 4: return 16'(int'($urandom_range(0, 40)) - 20);
			5: return 16'(int'($urandom_range(0, 600)) - 300);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		b.opcode = 3'($urandom_range(0, 7));
		b.a_num = rand_operand();
		b.a_den = rand_operand();
		b.b_num = rand_operand();
		b.b_den = rand_operand();
		// Most beats carry normalized operands with positive denominators,
		// which is what the comparisons assume.
		if ($urandom_range(0, 3) != 0) begin
			if (b.a_den <= 0) begin
				b.a_den = 16'($urandom_range(1, 32767));
			end
			if (b.b_den <= 0) begin
				b.b_den = 16'($urandom_range(1, 32767));
			end
		end
		return b;
	endfunction

	function automatic in_beat_t make_beat(op_t op, int an, int ad, int bn, int bd);
		in_beat_t b;
		b.opcode = op;
		b.a_num = 16'(an);
		b.a_den = 16'(ad);
		b.b_num = 16'(bn);
		b.b_den = 16'(bd);
		return b;
	endfunction

	// Append one beat to the tail of the pending queue.
	task automatic enqueue_beat(in_beat_t b);
		pending_beats = {pending_beats, b};
	endtask

	// Driver: present the head of the pending queue. A beat stays on the bus
	// until it is accepted; a new one is chosen only after acceptance.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && accepted_in != driven_cnt) begin
				// The presented beat has not been taken yet and stays as is.
			end else if (pending_beats.size() > 0 && !hold_send &&
				$urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_beats[0];
				driven_cnt++;
			end else begin
				in_valid <= 1'b0;
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Input acceptance: predict the result of every beat the block takes.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_fracs = {expected_fracs, predict_frac(in_data)};
			void'(pending_beats.pop_front());
			accepted_in++;
		end
	end

	// Monitor: compare each output beat with the oldest prediction.
	always @(posedge clk) begin
		out_beat_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_fracs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected output beat %h", out_data);
				end
			end else begin
				exp_b = expected_fracs.pop_front();
				if (out_data.res_num !== exp_b.res_num ||
					out_data.res_den !== exp_b.res_den ||
					out_data.cmp_true !== exp_b.cmp_true) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display({"mismatch: expected num %0d den %0d flag %0b, ",
							"got num %0d den %0d flag %0b"},
							exp_b.res_num, exp_b.res_den, exp_b.cmp_true,
							out_data.res_num, out_data.res_den, out_data.cmp_true);
					end
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_beats.size() > 0 || in_valid || expected_fracs.size() > 0) begin
			@(posedge clk);
		end
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) begin
			enqueue_beat(rand_beat());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		hold_send = 1'b0;
		stim_done = 1'b0;
		send_idle_pct = 23;
		recv_idle_pct = 85;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed beats: every opcode, operand extremes, a zero raw
		// denominator, a zero numerator and unnormalized operands.
		enqueue_beat(make_beat(OP_NORM, 6, -4, 99, 99));
		enqueue_beat(make_beat(OP_NORM, -7, 0, 0, 0));
		enqueue_beat(make_beat(OP_NORM, 0, -5, 1, 1));
		enqueue_beat(make_beat(OP_NORM, -32768, -32768, -32768, 32767));
		enqueue_beat(make_beat(OP_ADD, 1, 2, 1, 3));
		enqueue_beat(make_beat(OP_ADD, 32767, 32767, 32767, 32767));
		enqueue_beat(make_beat(OP_ADD, -32768, 1, -32768, 1));
		enqueue_beat(make_beat(OP_SUB, 1, 2, 1, 2));
		enqueue_beat(make_beat(OP_SUB, -32768, 32767, 32767, -32768));
		enqueue_beat(make_beat(OP_MUL, -32768, 1, -32768, 1));
		enqueue_beat(make_beat(OP_MUL, 3, 0, 5, 7));
		enqueue_beat(make_beat(OP_MUL, 2, -3, 9, 4));
		enqueue_beat(make_beat(OP_DIV, 3, 4, 0, 5));
		enqueue_beat(make_beat(OP_DIV, -32768, 1, 1, -32768));
		enqueue_beat(make_beat(OP_DIV, 5, 6, -10, 3));
		enqueue_beat(make_beat(OP_EQ, 1, 2, 2, 4));
		enqueue_beat(make_beat(OP_EQ, 1, 2, 1, 3));
		enqueue_beat(make_beat(OP_LT, 1, 3, 1, 2));
		enqueue_beat(make_beat(OP_LT, 1, -3, 1, 2));
		enqueue_beat(make_beat(OP_GT, 32767, 1, -32768, 1));
		enqueue_beat(make_beat(OP_GT, 1, 2, 1, 2));
		enqueue_beat(make_beat(OP_ADD, 0, 0, 0, 0));
		enqueue_beat(make_beat(OP_NORM, -1, -1, -1, -1));

		queue_random(NumRandom / 3);
		wait_drained();

		// Swap idle rates; partway through, hold the sender until every
		// result has come, then let it go on.
		send_idle_pct = 85;
		recv_idle_pct = 23;
		queue_random(NumRandom / 3);
		repeat (5000) @(posedge clk);
		hold_send = 1'b1;
		while (in_valid || expected_fracs.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		hold_send = 1'b0;
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(NumRandom - 2 * (NumRandom / 3));
		wait_drained();
		repeat (50) @(posedge clk);
		stim_done = 1'b1;
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog: fails the run if the stimulus has not finished in time.
	initial begin
		#300ms;
		if (!stim_done) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

// ===== rational_arithmetic_unit.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_queue.sv
rtl/core/rau_reduce.sv
rtl/core/rational_arithmetic_unit.sv
tb/sv/tb.sv
